FILE: hdl/uorb_pkg.sv
// shared constants, types and helpers for the uart ring buffer block
package uorb_pkg;

	// ring geometry
	localparam int RING_DEPTH = 64;
	localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int BYTE_W     = 8;
	localparam int REQ_W      = 3;
	localparam int LEVEL_W    = 7;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_RX_PUT  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_READ    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_PEEK    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SEND    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_TX_DONE = 3'd4;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic take;
		logic exec;
		logic read;
		logic load;
	} ctrl_cmd_t;

	// pointer advance with wrap at the ring end
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(RING_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

endpackage

FILE: hdl/uorb_ram.sv
// generic single-write, single-read ram with registered read data
module uorb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/uorb_ctrl.sv
// sequencer: request handshake, execute, ram read, load and result handshake
module uorb_ctrl
	import uorb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	output logic      res_valid,
	input  logic      res_stall,
	output ctrl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_LOAD = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// handshake outputs come from the state alone
	assign req_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_OUT);

	// commands to the datapath
	assign cmd.take = (state_q == S_IDLE) && req_valid;
	assign cmd.exec = (state_q == S_EXEC);
	assign cmd.read = (state_q == S_READ);
	assign cmd.load = (state_q == S_LOAD);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: state_d = S_READ;
			S_READ: state_d = S_LOAD;
			S_LOAD: state_d = S_OUT;
			S_OUT: begin
				if (!res_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hdl/uorb_dpath.sv
// datapath: ring pointers, counts, valid bits, the two rings and result registers
module uorb_dpath
	import uorb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [BYTE_W-1:0]  data_byte,
	output logic [BYTE_W-1:0]  read_byte,
	output logic [LEVEL_W-1:0] rx_level,
	output logic               tx_start,
	output logic [BYTE_W-1:0]  tx_byte,
	output logic               tx_idle
);

	// latched request
	logic [REQ_W-1:0]  req_type_q;
	logic [BYTE_W-1:0] data_q;

	// ring state
	logic [PTR_W-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
	logic [CNT_W-1:0] rx_cnt_q, tx_cnt_q;
	logic             tx_stalled_q;
	logic [RING_DEPTH-1:0] rx_vld_q, tx_vld_q;

	// next values
	logic [PTR_W-1:0] rx_head_d, rx_tail_d, tx_head_d, tx_tail_d, tx_tail1;
	logic [CNT_W-1:0] rx_cnt_d, tx_cnt_d, tx_cnt1;
	logic             tx_stalled_d;
	logic             rx_we, tx_we;
	logic [PTR_W-1:0] rx_raddr_d, tx_raddr_d;
	logic             rx_use_d, tx_use_d;

	// pending read addresses and result selects
	logic [PTR_W-1:0]  rx_raddr_q, tx_raddr_q;
	logic              rx_use_q, tx_use_q;
	logic [BYTE_W-1:0] rx_rdata, tx_rdata;

	// result registers
	logic [BYTE_W-1:0]  read_byte_q, tx_byte_q;
	logic [LEVEL_W-1:0] rx_level_q;
	logic               tx_start_q, tx_idle_q;

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_type_q <= req_type;
			data_q     <= data_byte;
		end
	end

	// execute step: writes, pointer moves and read address choice
	always_comb begin
		rx_we        = 1'b0;
		tx_we        = 1'b0;
		rx_head_d    = rx_head_q;
		rx_tail_d    = rx_tail_q;
		rx_cnt_d     = rx_cnt_q;
		tx_head_d    = tx_head_q;
		tx_tail_d    = tx_tail_q;
		tx_cnt_d     = tx_cnt_q;
		tx_stalled_d = tx_stalled_q;
		tx_tail1     = tx_tail_q;
		tx_cnt1      = tx_cnt_q;
		rx_raddr_d   = rx_tail_q;
		tx_raddr_d   = tx_tail_q;
		rx_use_d     = 1'b0;
		tx_use_d     = 1'b0;
		unique case (req_type_q)
			REQ_RX_PUT: begin
				rx_we     = 1'b1;
				rx_head_d = ptr_next(rx_head_q);
				if (rx_cnt_q < CNT_W'(RING_DEPTH)) begin
					rx_cnt_d = rx_cnt_q + 1'b1;
				end else begin
					rx_tail_d = ptr_next(rx_tail_q);
				end
			end
			REQ_READ: begin
				if (rx_cnt_q != '0) begin
					rx_use_d  = 1'b1;
					rx_tail_d = ptr_next(rx_tail_q);
					rx_cnt_d  = rx_cnt_q - 1'b1;
				end
			end
			REQ_PEEK: begin
				rx_use_d = 1'b1;
			end
			REQ_SEND: begin
				tx_we     = 1'b1;
				tx_head_d = ptr_next(tx_head_q);
				// full ring drops its oldest byte
				if (tx_cnt_q < CNT_W'(RING_DEPTH)) begin
					tx_cnt1 = tx_cnt_q + 1'b1;
				end else begin
					tx_tail1 = ptr_next(tx_tail_q);
				end
				if (tx_stalled_q) begin
					tx_stalled_d = 1'b0;
					tx_use_d     = 1'b1;
					tx_raddr_d   = tx_tail1;
					tx_tail_d    = ptr_next(tx_tail1);
					tx_cnt_d     = tx_cnt1 - 1'b1;
				end else begin
					tx_tail_d = tx_tail1;
					tx_cnt_d  = tx_cnt1;
				end
			end
			REQ_TX_DONE: begin
				if (tx_cnt_q != '0) begin
					tx_use_d  = 1'b1;
					tx_tail_d = ptr_next(tx_tail_q);
					tx_cnt_d  = tx_cnt_q - 1'b1;
				end else begin
					tx_stalled_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// control state, cleared at reset; valid bits stand in for a zeroed store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q    <= '0;
			rx_tail_q    <= '0;
			rx_cnt_q     <= '0;
			tx_head_q    <= '0;
			tx_tail_q    <= '0;
			tx_cnt_q     <= '0;
			tx_stalled_q <= 1'b1;
			rx_vld_q     <= '0;
			tx_vld_q     <= '0;
			rx_use_q     <= 1'b0;
			tx_use_q     <= 1'b0;
		end else if (cmd.exec) begin
			rx_head_q    <= rx_head_d;
			rx_tail_q    <= rx_tail_d;
			rx_cnt_q     <= rx_cnt_d;
			tx_head_q    <= tx_head_d;
			tx_tail_q    <= tx_tail_d;
			tx_cnt_q     <= tx_cnt_d;
			tx_stalled_q <= tx_stalled_d;
			rx_use_q     <= rx_use_d;
			tx_use_q     <= tx_use_d;
			if (rx_we) begin
				rx_vld_q[rx_head_q] <= 1'b1;
			end
			if (tx_we) begin
				tx_vld_q[tx_head_q] <= 1'b1;
			end
		end
	end

	// read addresses held for the ram read step
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rx_raddr_q <= rx_raddr_d;
			tx_raddr_q <= tx_raddr_d;
		end
	end

	// receive and transmit rings
	uorb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RING_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (cmd.exec && rx_we),
		.waddr (rx_head_q),
		.wdata (data_q),
		.re    (cmd.read),
		.raddr (rx_raddr_q),
		.rdata (rx_rdata)
	);

	uorb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RING_DEPTH)
	) u_tx_ram (
		.clk   (clk),
		.we    (cmd.exec && tx_we),
		.waddr (tx_head_q),
		.wdata (data_q),
		.re    (cmd.read),
		.raddr (tx_raddr_q),
		.rdata (tx_rdata)
	);

	// result load; a never-written entry reads as zero
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			read_byte_q <= (rx_use_q && rx_vld_q[rx_raddr_q]) ? rx_rdata : '0;
			tx_byte_q   <= (tx_use_q && tx_vld_q[tx_raddr_q]) ? tx_rdata : '0;
			tx_start_q  <= tx_use_q;
			rx_level_q  <= LEVEL_W'(rx_cnt_q);
			tx_idle_q   <= tx_stalled_q;
		end
	end

	assign read_byte = read_byte_q;
	assign rx_level  = rx_level_q;
	assign tx_start  = tx_start_q;
	assign tx_byte   = tx_byte_q;
	assign tx_idle   = tx_idle_q;

endmodule

FILE: hdl/uart_overwrite_ring_buffers_core.sv
// top level of the uart receive and transmit overwrite ring buffers
// an accepted request walks the sequencer through execute, ring ram read, result load
//   and the result handshake; no new request is taken until its result is accepted
// reset: asynchronous, clears pointers, counts and per-entry valid bits at once,
//   marks the transmitter idle; no clearing pass, requests are taken right away
module uart_overwrite_ring_buffers_core
	import uorb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [BYTE_W-1:0]  data_byte,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [BYTE_W-1:0]  read_byte,
	output logic [LEVEL_W-1:0] rx_level,
	output logic               tx_start,
	output logic [BYTE_W-1:0]  tx_byte,
	output logic               tx_idle
);

	ctrl_cmd_t cmd;

	// sequencer
	uorb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd)
	);

	// rings and result registers
	uorb_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_type  (req_type),
		.data_byte (data_byte),
		.read_byte (read_byte),
		.rx_level  (rx_level),
		.tx_start  (tx_start),
		.tx_byte   (tx_byte),
		.tx_idle   (tx_idle)
	);

endmodule

FILE: hdl/uorb_checker.sv
// port-level checks for the uart ring buffer top level, bound to it
module uorb_checker
	import uorb_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               res_valid,
	input logic               res_stall,
	input logic [BYTE_W-1:0]  read_byte,
	input logic [LEVEL_W-1:0] rx_level,
	input logic               tx_start,
	input logic [BYTE_W-1:0]  tx_byte,
	input logic               tx_idle
);

	// one request in flight: an accepted request blocks the next one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while another is in flight");

	// no request is taken while a result waits
	a_no_take_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> req_stall)
		else $error("request path open while a result is pending");

	// transmit byte is zero unless a byte is handed over
	a_tx_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !tx_start) |-> (tx_byte == '0))
		else $error("tx_byte set without tx_start");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(read_byte)
			&& $stable(rx_level) && $stable(tx_start) && $stable(tx_byte)
			&& $stable(tx_idle)))
		else $error("stalled result changed");

endmodule

bind uart_overwrite_ring_buffers_core uorb_checker u_uorb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.read_byte (read_byte),
	.rx_level  (rx_level),
	.tx_start  (tx_start),
	.tx_byte   (tx_byte),
	.tx_idle   (tx_idle)
);

FILE: sim/tb.sv
// testbench for the uart receive and transmit overwrite ring buffers
`timescale 1ns / 1ps

module tb;
	import uorb_pkg::*;

	// request kinds the block has no use for
	localparam logic [REQ_W-1:0] REQ_RSVD_LO  = 3'd5;
	localparam logic [REQ_W-1:0] REQ_RSVD_MID = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RSVD_HI  = 3'd7;

	localparam int RANDOM_ITEMS   = 1500;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int PLAN_ROWS      = 24;

	typedef struct packed {
		logic [BYTE_W-1:0]  read_byte;
		logic [LEVEL_W-1:0] rx_level;
		logic               tx_start;
		logic [BYTE_W-1:0]  tx_byte;
		logic               tx_idle;
	} ring_result_t;

	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic [BYTE_W-1:0] data;
		logic              typed;
		ring_result_t      want;
	} plan_row_t;

	typedef enum int {MIX_RX_FILL, MIX_RX_DRAIN, MIX_TX_FILL, MIX_TX_DRAIN, MIX_ANY} traffic_mix_t;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	// directed requests; typed rows carry their result, the rest go to the predictor
	localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
		'{REQ_PEEK,     8'h00, 1'b1, '{8'h00, 7'd0, 1'b0, 8'h00, 1'b1}},
		'{REQ_READ,     8'h3C, 1'b1, '{8'h00, 7'd0, 1'b0, 8'h00, 1'b1}},
		'{REQ_TX_DONE,  8'h00, 1'b1, '{8'h00, 7'd0, 1'b0, 8'h00, 1'b1}},
		'{REQ_RX_PUT,   8'hFF, 1'b1, '{8'h00, 7'd1, 1'b0, 8'h00, 1'b1}},
		'{REQ_PEEK,     8'h00, 1'b1, '{8'hFF, 7'd1, 1'b0, 8'h00, 1'b1}},
		'{REQ_READ,     8'h00, 1'b1, '{8'hFF, 7'd0, 1'b0, 8'h00, 1'b1}},
		'{REQ_RX_PUT,   8'h00, 1'b1, '{8'h00, 7'd1, 1'b0, 8'h00, 1'b1}},
		'{REQ_RX_PUT,   8'h81, 1'b1, '{8'h00, 7'd2, 1'b0, 8'h00, 1'b1}},
		'{REQ_PEEK,     8'hFF, 1'b1, '{8'h00, 7'd2, 1'b0, 8'h00, 1'b1}},
		'{REQ_SEND,     8'hA5, 1'b1, '{8'h00, 7'd2, 1'b1, 8'hA5, 1'b0}},
		'{REQ_SEND,     8'h5A, 1'b1, '{8'h00, 7'd2, 1'b0, 8'h00, 1'b0}},
		'{REQ_SEND,     8'hFF, 1'b0, '0},
		'{REQ_SEND,     8'h00, 1'b0, '0},
		'{REQ_TX_DONE,  8'hFF, 1'b1, '{8'h00, 7'd2, 1'b1, 8'h5A, 1'b0}},
		'{REQ_TX_DONE,  8'h00, 1'b0, '0},
		'{REQ_TX_DONE,  8'h00, 1'b0, '0},
		'{REQ_TX_DONE,  8'h00, 1'b1, '{8'h00, 7'd2, 1'b0, 8'h00, 1'b1}},
		'{REQ_RSVD_LO,  8'hFF, 1'b1, '{8'h00, 7'd2, 1'b0, 8'h00, 1'b1}},
		'{REQ_RSVD_MID, 8'h55, 1'b1, '{8'h00, 7'd2, 1'b0, 8'h00, 1'b1}},
		'{REQ_RSVD_HI,  8'hAA, 1'b1, '{8'h00, 7'd2, 1'b0, 8'h00, 1'b1}},
		'{REQ_READ,     8'h00, 1'b0, '0},
		'{REQ_READ,     8'h00, 1'b0, '0},
		'{REQ_READ,     8'hFF, 1'b1, '{8'h00, 7'd0, 1'b0, 8'h00, 1'b1}},
		'{REQ_PEEK,     8'h00, 1'b0, '0}
	};

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [REQ_W-1:0]   req_type;
	logic [BYTE_W-1:0]  data_byte;
	logic               res_valid;
	logic               res_stall;
	logic [BYTE_W-1:0]  read_byte;
	logic [LEVEL_W-1:0] rx_level;
	logic               tx_start;
	logic [BYTE_W-1:0]  tx_byte;
	logic               tx_idle;

	// predictor copy of both rings
	logic [BYTE_W-1:0] rx_mem [RING_DEPTH];
	logic [BYTE_W-1:0] tx_mem [RING_DEPTH];
	logic [PTR_W-1:0]  rx_head, rx_tail, tx_head, tx_tail;
	logic [CNT_W-1:0]  rx_count, tx_count;
	logic              tx_parked;

	ring_result_t pending_results [$];
	ring_result_t oldest_result;
	int           mismatches = 0;
	int           burst_left = 0;

	uart_overwrite_ring_buffers_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.data_byte (data_byte),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.read_byte (read_byte),
		.rx_level  (rx_level),
		.tx_start  (tx_start),
		.tx_byte   (tx_byte),
		.tx_idle   (tx_idle)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ring position step with wrap at the last entry
	function automatic logic [PTR_W-1:0] ring_step(input logic [PTR_W-1:0] pos);
		return (pos == PTR_W'(RING_DEPTH - 1)) ? '0 : pos + 1'b1;
	endfunction

	// advance the ring state by one request and work out its result
	function automatic ring_result_t predict_ring_result(input logic [REQ_W-1:0] kind,
			input logic [BYTE_W-1:0] data);
		ring_result_t r;
		r = '0;
		case (kind)
		REQ_RX_PUT: begin
			rx_mem[rx_head] = data;
			rx_head = ring_step(rx_head);
			if (rx_count < RING_DEPTH) begin
				rx_count = rx_count + 1'b1;
			end else begin
				rx_tail = ring_step(rx_tail);
			end
		end
		REQ_READ: begin
			if (rx_count != 0) begin
				r.read_byte = rx_mem[rx_tail];
				rx_tail = ring_step(rx_tail);
				rx_count = rx_count - 1'b1;
			end
		end
		REQ_PEEK: begin
			r.read_byte = rx_mem[rx_tail];
		end
		REQ_SEND: begin
			tx_mem[tx_head] = data;
			tx_head = ring_step(tx_head);
			if (tx_count < RING_DEPTH) begin
				tx_count = tx_count + 1'b1;
			end else begin
				tx_tail = ring_step(tx_tail);
			end
			// idle transmitter takes the oldest byte straight away
			if (tx_parked) begin
				tx_parked = 1'b0;
				r.tx_start = 1'b1;
				if (tx_count != 0) begin
					r.tx_byte = tx_mem[tx_tail];
					tx_tail = ring_step(tx_tail);
					tx_count = tx_count - 1'b1;
				end
			end
		end
		REQ_TX_DONE: begin
			if (tx_count != 0) begin
				r.tx_start = 1'b1;
				r.tx_byte = tx_mem[tx_tail];
				tx_tail = ring_step(tx_tail);
				tx_count = tx_count - 1'b1;
			end else begin
				tx_parked = 1'b1;
			end
		end
		default: begin
		end
		endcase
		r.rx_level = LEVEL_W'(rx_count);
		r.tx_idle = tx_parked;
		return r;
	endfunction

	// request kind drawn according to the traffic mix
	function automatic logic [REQ_W-1:0] pick_kind(input traffic_mix_t mix);
		int roll;
		roll = $urandom_range(0, 99);
		case (mix)
		MIX_RX_FILL:  return (roll < 85) ? REQ_RX_PUT : ((roll < 93) ? REQ_READ : REQ_PEEK);
		MIX_RX_DRAIN: return (roll < 60) ? REQ_READ : ((roll < 85) ? REQ_PEEK : REQ_RX_PUT);
		MIX_TX_FILL:  return (roll < 80) ? REQ_SEND : REQ_TX_DONE;
		MIX_TX_DRAIN: return (roll < 80) ? REQ_TX_DONE : REQ_SEND;
		default:      return REQ_W'($urandom_range(REQ_RX_PUT, REQ_TX_DONE));
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
			input logic [BYTE_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// drive one request from a falling edge and hold it until taken; returns at a falling edge
	task automatic send_request(input logic [REQ_W-1:0] kind, input logic [BYTE_W-1:0] data,
			input logic typed, input ring_result_t typed_want);
		int gap;
		ring_result_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req_type  <= kind;
		data_byte <= data;
		do @(posedge clk); while (req_stall);
		predicted = predict_ring_result(kind, data);
		pending_results.push_back(typed ? typed_want : predicted);
		@(negedge clk);
	endtask

	// receiver stall pattern, switching between stretches of different pressure
	initial begin
		stall_mode_t mode;
		int stretch;
		stretch = 0;
		mode = STALL_NONE;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stretch == 0) begin
				mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_TOGGLE));
				stretch = $urandom_range(20, 200);
			end
			stretch--;
			case (mode)
			STALL_NONE:   res_stall <= 1'b0;
			STALL_LIGHT:  res_stall <= ($urandom_range(0, 2) == 0);
			STALL_HEAVY:  res_stall <= ($urandom_range(0, 7) != 0);
			default:      res_stall <= ~res_stall;
			endcase
		end
	end

	// result checker against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with no request pending, expected none, actual %0h %0h %0b %0h %0b",
					$time, read_byte, rx_level, tx_start, tx_byte, tx_idle);
				mismatches++;
			end else begin
				oldest_result = pending_results.pop_front();
				check_field("read_byte", oldest_result.read_byte, read_byte);
				check_field("rx_level", BYTE_W'(oldest_result.rx_level), BYTE_W'(rx_level));
				check_field("tx_start", BYTE_W'(oldest_result.tx_start), BYTE_W'(tx_start));
				check_field("tx_byte", oldest_result.tx_byte, tx_byte);
				check_field("tx_idle", BYTE_W'(oldest_result.tx_idle), BYTE_W'(tx_idle));
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t ns: timeout, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// main sequence
	initial begin
		int row;
		int sent;
		int run_len;
		int roll;
		traffic_mix_t mix;
		logic [REQ_W-1:0] kind;
		logic [BYTE_W-1:0] data;

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_type  = REQ_RX_PUT;
		data_byte = '0;
		for (row = 0; row < RING_DEPTH; row++) begin
			rx_mem[row] = '0;
			tx_mem[row] = '0;
		end
		rx_head   = '0;
		rx_tail   = '0;
		rx_count  = '0;
		tx_head   = '0;
		tx_tail   = '0;
		tx_count  = '0;
		tx_parked = 1'b1;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		for (row = 0; row < PLAN_ROWS; row++) begin
			send_request(DIRECTED_PLAN[row].kind, DIRECTED_PLAN[row].data,
				DIRECTED_PLAN[row].typed, DIRECTED_PLAN[row].want);
		end

		// random runs, most leaning on one ring and direction, with a little noise
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mix = traffic_mix_t'($urandom_range(MIX_RX_FILL, MIX_ANY));
			run_len = $urandom_range(1, 160);
			repeat (run_len) begin
				roll = $urandom_range(0, 7);
				data = (roll == 0) ? 8'h00 : ((roll == 1) ? 8'hFF : BYTE_W'($urandom_range(0, 255)));
				if ($urandom_range(0, 31) == 0) begin
					kind = REQ_W'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
				end else begin
					kind = pick_kind(mix);
					sent++;
				end
				send_request(kind, data, 1'b0, '0);
			end
		end
		req_valid <= 1'b0;

		// let the outstanding results come back
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
